// ===== sv/hpcs_pkg.sv =====
// ----------------------------------------------------------------------------
// hpcs_pkg
// Shared types, codes and a helper function for the heat pump cycle sequencer.
// ----------------------------------------------------------------------------
package hpcs_pkg;

    localparam int unsigned SecW   = 16;
    localparam int unsigned ModeW  = 3;
    localparam int unsigned ClassW = 2;
    localparam int unsigned CfgIdxW = 3;

    localparam logic [SecW-1:0] SecMax = {SecW{1'b1}};

    // Tank temperature classes. Code 3 means nothing and acts as within band.
    localparam logic [ClassW-1:0] ClassBelow = 2'd1;
    localparam logic [ClassW-1:0] ClassAbove = 2'd2;

    // Encoded mode values as seen on the result channel.
    localparam logic [ModeW-1:0] ModeCodeCooldown  = 3'd0;
    localparam logic [ModeW-1:0] ModeCodeOffLock   = 3'd1;
    localparam logic [ModeW-1:0] ModeCodeOff       = 3'd2;
    localparam logic [ModeW-1:0] ModeCodeFlowCheck = 3'd3;
    localparam logic [ModeW-1:0] ModeCodeOnLock    = 3'd4;
    localparam logic [ModeW-1:0] ModeCodeOn        = 3'd5;
    localparam logic [ModeW-1:0] ModeCodeError     = 3'd6;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CfgCooldown    = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgOffLock     = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgOnLock      = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgFlowTimeout = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgErrorHold   = 3'd4;

    // Configuration reset values.
    localparam logic [SecW-1:0] CooldownReset    = 16'd60;
    localparam logic [SecW-1:0] OffLockReset     = 16'd300;
    localparam logic [SecW-1:0] OnLockReset      = 16'd300;
    localparam logic [SecW-1:0] FlowTimeoutReset = 16'd30;
    localparam logic [SecW-1:0] ErrorHoldReset   = 16'd600;

    // Mode state machine, one-hot.
    typedef enum logic [6:0] {
        MODE_COOLDOWN   = 7'b000_0001,
        MODE_OFF_LOCK   = 7'b000_0010,
        MODE_OFF        = 7'b000_0100,
        MODE_FLOW_CHECK = 7'b000_1000,
        MODE_ON_LOCK    = 7'b001_0000,
        MODE_ON         = 7'b010_0000,
        MODE_ERROR      = 7'b100_0000
    } mode_t;

    // Timing limits from the configuration registers.
    typedef struct packed {
        logic [SecW-1:0] cooldown;
        logic [SecW-1:0] off_lock;
        logic [SecW-1:0] on_lock;
        logic [SecW-1:0] flow_timeout;
        logic [SecW-1:0] error_hold;
    } cfg_t;

    // Sequencer state carried from tick to tick.
    typedef struct packed {
        mode_t           mode;
        logic [SecW-1:0] seconds;
        logic            compressor;
        logic            primary_pump;
        logic            secondary_pump;
    } seq_state_t;

    // One tick's input beat.
    typedef struct packed {
        logic [ClassW-1:0] tank_temp_class;
        logic              flow_ok;
        logic              sensors_valid;
    } tick_t;

    // Map the one-hot mode to its output code.
    function automatic logic [ModeW-1:0] mode_code(input mode_t m);
        logic [ModeW-1:0] code;
        case (m)
            MODE_COOLDOWN:   code = ModeCodeCooldown;
            MODE_OFF_LOCK:   code = ModeCodeOffLock;
            MODE_OFF:        code = ModeCodeOff;
            MODE_FLOW_CHECK: code = ModeCodeFlowCheck;
            MODE_ON_LOCK:    code = ModeCodeOnLock;
            MODE_ON:         code = ModeCodeOn;
            MODE_ERROR:      code = ModeCodeError;
            default:         code = ModeCodeOffLock;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/hpcs_cfg.sv =====
// ----------------------------------------------------------------------------
// hpcs_cfg
// Configuration register file holding the five timing limits in seconds.
// ----------------------------------------------------------------------------
module hpcs_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [hpcs_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [hpcs_pkg::SecW-1:0]     cfg_wdata,
    output hpcs_pkg::cfg_t                cfg
);
    import hpcs_pkg::*;

    cfg_t cfg_reg;

    // Write the addressed register; indexes past the last one are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cooldown     <= CooldownReset;
            cfg_reg.off_lock     <= OffLockReset;
            cfg_reg.on_lock      <= OnLockReset;
            cfg_reg.flow_timeout <= FlowTimeoutReset;
            cfg_reg.error_hold   <= ErrorHoldReset;
        end else if (cfg_we) begin
            case (cfg_index)
                CfgCooldown:    cfg_reg.cooldown     <= cfg_wdata;
                CfgOffLock:     cfg_reg.off_lock     <= cfg_wdata;
                CfgOnLock:      cfg_reg.on_lock      <= cfg_wdata;
                CfgFlowTimeout: cfg_reg.flow_timeout <= cfg_wdata;
                CfgErrorHold:   cfg_reg.error_hold   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/hpcs_step.sv =====
// ----------------------------------------------------------------------------
// hpcs_step
// Next-state logic for one tick: advances the seconds counter, runs the mode
// checks in order when the sensors are valid and settles relays, mode and the mode-changed flag.
// ----------------------------------------------------------------------------
module hpcs_step (
    input  hpcs_pkg::cfg_t        cfg,
    input  hpcs_pkg::seq_state_t  cur,
    input  hpcs_pkg::tick_t       tick,
    output hpcs_pkg::seq_state_t  nxt,
    output logic                  moved
);
    import hpcs_pkg::*;

    logic [SecW-1:0] t;
    logic            below;
    logic            above;

    // Saturating advance of the seconds counter.
    assign t     = (cur.seconds == SecMax) ? cur.seconds : cur.seconds + 1'b1;
    assign below = (tick.tank_temp_class == ClassBelow);
    assign above = (tick.tank_temp_class == ClassAbove);

    // Mode checks; a later check in the same tick overrides an earlier one.
    always_comb begin
        nxt   = cur;
        moved = 1'b0;
        if (tick.sensors_valid) begin
            case (cur.mode)
                MODE_COOLDOWN: begin
                    if (t > cfg.cooldown) begin
                        nxt.primary_pump   = 1'b0;
                        nxt.secondary_pump = 1'b0;
                        nxt.mode           = MODE_OFF_LOCK;
                        moved              = 1'b1;
                    end
                end
                MODE_OFF_LOCK: begin
                    if (t > cfg.off_lock) begin
                        nxt.mode = MODE_OFF;
                        moved    = 1'b1;
                    end
                end
                MODE_OFF: begin
                    if (below) begin
                        nxt.primary_pump   = 1'b1;
                        nxt.secondary_pump = 1'b1;
                        nxt.mode           = MODE_FLOW_CHECK;
                        moved              = 1'b1;
                    end
                    // Flow with the pumps meant to be off is a fault.
                    if (tick.flow_ok) begin
                        nxt.mode = MODE_ERROR;
                        moved    = 1'b1;
                    end
                end
                MODE_FLOW_CHECK: begin
                    if (t < cfg.flow_timeout) begin
                        if (tick.flow_ok) begin
                            nxt.compressor = 1'b1;
                            nxt.mode       = MODE_ON_LOCK;
                            moved          = 1'b1;
                        end
                    end else begin
                        nxt.mode = MODE_ERROR;
                        moved    = 1'b1;
                    end
                end
                MODE_ON_LOCK: begin
                    if (t > cfg.on_lock) begin
                        nxt.mode = MODE_ON;
                        moved    = 1'b1;
                    end
                    if (!tick.flow_ok) begin
                        nxt.compressor     = 1'b0;
                        nxt.primary_pump   = 1'b0;
                        nxt.secondary_pump = 1'b0;
                        nxt.mode           = MODE_OFF_LOCK;
                        moved              = 1'b1;
                    end
                end
                MODE_ON: begin
                    if (above) begin
                        nxt.compressor = 1'b0;
                        nxt.mode       = MODE_COOLDOWN;
                        moved          = 1'b1;
                    end
                    if (!tick.flow_ok) begin
                        nxt.compressor     = 1'b0;
                        nxt.primary_pump   = 1'b0;
                        nxt.secondary_pump = 1'b0;
                        nxt.mode           = MODE_OFF_LOCK;
                        moved              = 1'b1;
                    end
                end
                MODE_ERROR: begin
                    if (t > cfg.error_hold) begin
                        nxt.mode = MODE_OFF_LOCK;
                        moved    = 1'b1;
                    end else begin
                        nxt.compressor     = 1'b0;
                        nxt.primary_pump   = 1'b0;
                        nxt.secondary_pump = 1'b0;
                    end
                end
                default: begin
                    nxt.compressor     = 1'b0;
                    nxt.primary_pump   = 1'b0;
                    nxt.secondary_pump = 1'b0;
                    nxt.mode           = MODE_OFF_LOCK;
                    moved              = 1'b1;
                end
            endcase
        end
        // Any transition clears the counter, otherwise it keeps the advance.
        nxt.seconds = moved ? '0 : t;
    end

endmodule

// ===== sv/heat_pump_cycle_sequencer.sv =====
// ----------------------------------------------------------------------------
// heat_pump_cycle_sequencer
// A tick beat passes through the input register, then the result register.
// Throughput: one tick per cycle unless m_ready stalls; input and result
// registers hold one beat each, so one input is taken while a result waits.
// Reset (aresetn low, synchronous): mode off lock, counter zero, relays off,
// timing limits at their defaults, both pipeline stages empty.
// Sequences compressor and pump relays through cooldown, lock, flow proving
// and error hold modes, one one-second tick per input beat.
// ----------------------------------------------------------------------------
module heat_pump_cycle_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_we,
    input  logic [hpcs_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [hpcs_pkg::SecW-1:0]     cfg_wdata,
    // Tick input channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [hpcs_pkg::ClassW-1:0]   s_tank_temp_class,
    input  logic                          s_flow_ok,
    input  logic                          s_sensors_valid,
    // Result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hpcs_pkg::ModeW-1:0]    m_mode,
    output logic                          m_compressor_on,
    output logic                          m_primary_pump_on,
    output logic                          m_secondary_pump_on,
    output logic                          m_mode_changed,
    output logic [hpcs_pkg::SecW-1:0]     m_seconds_in_mode
);
    import hpcs_pkg::*;

    cfg_t       cfg;
    tick_t      tick_reg;
    logic       tick_valid_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    logic       moved;
    logic       advance;

    logic [ModeW-1:0] mode_out_reg;
    logic             comp_out_reg;
    logic             pp_out_reg;
    logic             sp_out_reg;
    logic             changed_out_reg;
    logic [SecW-1:0]  sec_out_reg;
    logic             out_valid_reg;

    hpcs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hpcs_step u_step (
        .cfg   (cfg),
        .cur   (state_reg),
        .tick  (tick_reg),
        .nxt   (state_next),
        .moved (moved)
    );

    // The held tick moves on whenever the result register is free or draining.
    assign advance = tick_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !tick_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_valid_reg <= 1'b0;
        end else if (s_ready) begin
            tick_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            tick_reg.tank_temp_class <= s_tank_temp_class;
            tick_reg.flow_ok         <= s_flow_ok;
            tick_reg.sensors_valid   <= s_sensors_valid;
        end
    end

    // Sequencer state commits as the tick passes into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode           <= MODE_OFF_LOCK;
            state_reg.seconds        <= '0;
            state_reg.compressor     <= 1'b0;
            state_reg.primary_pump   <= 1'b0;
            state_reg.secondary_pump <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mode_out_reg    <= mode_code(state_next.mode);
            comp_out_reg    <= state_next.compressor;
            pp_out_reg      <= state_next.primary_pump;
            sp_out_reg      <= state_next.secondary_pump;
            changed_out_reg <= moved;
            sec_out_reg     <= state_next.seconds;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_mode              = mode_out_reg;
    assign m_compressor_on     = comp_out_reg;
    assign m_primary_pump_on   = pp_out_reg;
    assign m_secondary_pump_on = sp_out_reg;
    assign m_mode_changed      = changed_out_reg;
    assign m_seconds_in_mode   = sec_out_reg;

endmodule
